// File: rtl/brm_pkg.sv
// Package for the byte register machine execute unit.
// Holds sizes, opcodes, the result struct and small helper functions.
// No dependencies.
package brm_pkg;

   localparam int FIELD_W   = 4;
   localparam int DATA_W    = 8;
   localparam int REG_COUNT = 16;
   localparam int REG_AW    = $clog2(REG_COUNT);
   localparam int MEM_AW    = 4;
   localparam int MEM_DEPTH = 1 << MEM_AW;
   localparam int SUM_W     = DATA_W + 1;

   localparam int SP_INDEX = 6;
   localparam logic [DATA_W-1:0] SP_RESET = 8'h0F;

   localparam int REQ_TDATA_W = 16;
   localparam int RSP_TDATA_W = 16;
   localparam int RSP_TUSER_W = 3;

   localparam logic [FIELD_W-1:0] OP_SUB  = 4'd0;
   localparam logic [FIELD_W-1:0] OP_SW   = 4'd1;
   localparam logic [FIELD_W-1:0] OP_SLL  = 4'd2;
   localparam logic [FIELD_W-1:0] OP_SRL  = 4'd3;
   localparam logic [FIELD_W-1:0] OP_LW   = 4'd4;
   localparam logic [FIELD_W-1:0] OP_ORI  = 4'd5;
   localparam logic [FIELD_W-1:0] OP_BNE  = 4'd6;
   localparam logic [FIELD_W-1:0] OP_AND  = 4'd7;
   localparam logic [FIELD_W-1:0] OP_ADDI = 4'd8;
   localparam logic [FIELD_W-1:0] OP_NOR  = 4'd9;
   localparam logic [FIELD_W-1:0] OP_ANDI = 4'd10;
   localparam logic [FIELD_W-1:0] OP_OR   = 4'd11;
   localparam logic [FIELD_W-1:0] OP_SUBI = 4'd12;
   localparam logic [FIELD_W-1:0] OP_BEQ  = 4'd13;
   localparam logic [FIELD_W-1:0] OP_ADD  = 4'd14;
   localparam logic [FIELD_W-1:0] OP_JUMP = 4'd15;

   typedef struct packed {
      logic [FIELD_W-1:0] shown_index;
      logic [DATA_W-1:0]  shown_value;
      logic               reg_written;
      logic               mem_written;
      logic               zero_flag;
   } exec_result_type;

   // register field taken modulo REG_COUNT (REG_COUNT is at least half of 16)
   function automatic logic [REG_AW-1:0] reg_slot(input logic [FIELD_W-1:0] field);
      logic [FIELD_W:0] wide;
      wide = {1'b0, field};
      if (wide >= (FIELD_W+1)'(REG_COUNT)) begin
         wide = wide - (FIELD_W+1)'(REG_COUNT);
      end
      return wide[REG_AW-1:0];
   endfunction

   function automatic logic [DATA_W-1:0] reg_reset_value(input logic [REG_AW-1:0] slot);
      if (slot == REG_AW'(SP_INDEX % REG_COUNT)) begin
         return SP_RESET;
      end
      return '0;
   endfunction

endpackage

// File: rtl/brm_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module brm_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// File: rtl/brm_exec.sv
// Combinational execute logic: ALU, shifter, immediates and load/store address.
// Depends on brm_pkg.
module brm_exec import brm_pkg::*; (
   input  logic [FIELD_W-1:0] func,
   input  logic [FIELD_W-1:0] middle_field,
   input  logic [FIELD_W-1:0] last_field,
   input  logic [DATA_W-1:0]  rf_value,
   input  logic [DATA_W-1:0]  rm_value,
   input  logic [DATA_W-1:0]  mem_rd_data,
   output logic [MEM_AW-1:0]  mem_addr,
   output exec_result_type    result
);

   logic [DATA_W-1:0] imm;
   logic [SUM_W-1:0]  addr_sum;
   logic [DATA_W-1:0] shl;
   logic [DATA_W-1:0] shr;

   assign imm      = DATA_W'(last_field);
   assign addr_sum = SUM_W'(rf_value) + SUM_W'(last_field);
   assign mem_addr = addr_sum[MEM_AW-1:0];
   assign shl      = last_field[3] ? '0 : (rf_value << last_field[2:0]);
   assign shr      = last_field[3] ? '0 : (rf_value >> last_field[2:0]);

   always_comb begin
      result = '0;
      unique case (func)
         OP_SUB: begin
            result.shown_index = last_field;
            result.shown_value = rm_value - rf_value;
            result.reg_written = 1'b1;
         end
         OP_AND: begin
            result.shown_index = last_field;
            result.shown_value = rm_value & rf_value;
            result.reg_written = 1'b1;
         end
         OP_NOR: begin
            result.shown_index = last_field;
            result.shown_value = ~(rm_value | rf_value);
            result.reg_written = 1'b1;
         end
         OP_OR: begin
            result.shown_index = last_field;
            result.shown_value = rm_value | rf_value;
            result.reg_written = 1'b1;
         end
         OP_ADD: begin
            result.shown_index = last_field;
            result.shown_value = rm_value + rf_value;
            result.reg_written = 1'b1;
         end
         OP_SLL: begin
            result.shown_index = middle_field;
            result.shown_value = shl;
            result.reg_written = 1'b1;
         end
         OP_SRL: begin
            result.shown_index = middle_field;
            result.shown_value = shr;
            result.reg_written = 1'b1;
         end
         OP_ORI: begin
            result.shown_index = middle_field;
            result.shown_value = rf_value | imm;
            result.reg_written = 1'b1;
         end
         OP_ADDI: begin
            result.shown_index = middle_field;
            result.shown_value = rf_value + imm;
            result.reg_written = 1'b1;
         end
         OP_ANDI: begin
            result.shown_index = middle_field;
            result.shown_value = rf_value & imm;
            result.reg_written = 1'b1;
         end
         OP_SUBI: begin
            result.shown_index = middle_field;
            result.shown_value = rf_value - imm;
            result.reg_written = 1'b1;
         end
         OP_LW: begin
            result.shown_index = middle_field;
            result.shown_value = mem_rd_data;
            result.reg_written = 1'b1;
         end
         OP_SW: begin
            result.shown_index = middle_field;
            result.shown_value = rm_value;
            result.mem_written = 1'b1;
         end
         OP_BEQ: begin
            result.zero_flag = (rf_value == rm_value);
         end
         OP_BNE: begin
            result = '0;
         end
         OP_JUMP: begin
            result = '0;
         end
      endcase
   end

endmodule

// File: rtl/byte_register_machine_execute_unit.sv
// Top level of the byte register machine execute unit.
// Depends on brm_pkg, brm_ram and brm_exec.
//
// Usage:
//   req channel carries one instruction per word: req_tuser is the opcode,
//   req_tdata holds the three register/immediate fields. rsp channel returns
//   one word per instruction: register index and value written (or data
//   register and byte stored) in rsp_tdata, write/store/equal flags in
//   rsp_tuser.
//   From acceptance to rsp_tvalid an instruction passes the register file read
//   stage and then the execute/result register. One instruction is accepted per
//   cycle while rsp_tready stays high; the rate is set by the execute stage,
//   with a write-to-read bypass around the register file RAM.
//   Reset clears the pipeline valids, the data memory and the register file
//   valid bits; a register never written reads as its reset value (zero,
//   register six reads 15). When rsp_tready is low the result is held, the
//   instruction in the read stage waits, and req_tready drops once that stage
//   is occupied.
module byte_register_machine_execute_unit import brm_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   // [3:0] first_field, [7:4] middle_field, [11:8] last_field, [15:12] zero
   input  logic [REQ_TDATA_W-1:0] req_tdata,
   // [3:0] func
   input  logic [FIELD_W-1:0]     req_tuser,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   // [3:0] shown_index, [11:4] shown_value, [15:12] zero
   output logic [RSP_TDATA_W-1:0] rsp_tdata,
   // [0] reg_written, [1] mem_written, [2] zero_flag
   output logic [RSP_TUSER_W-1:0] rsp_tuser
);

   logic               s1_valid_ff, s1_valid_in;
   logic [FIELD_W-1:0] s1_func_ff, s1_first_ff, s1_middle_ff, s1_last_ff;
   logic               rsp_valid_ff, rsp_valid_in;
   exec_result_type    rsp_ff;
   logic               byp_valid_ff, byp_valid_in;
   logic [REG_AW-1:0]  byp_slot_ff;
   logic [DATA_W-1:0]  byp_data_ff;
   logic [REG_COUNT-1:0] rf_valid_ff;
   logic [DATA_W-1:0]  dmem_ff [MEM_DEPTH];

   logic               req_fire;
   logic               exe_fire;
   logic [REG_AW-1:0]  rd_slot_f, rd_slot_m;
   logic [REG_AW-1:0]  s1_slot_f, s1_slot_m;
   logic [REG_AW-1:0]  wr_slot;
   logic [DATA_W-1:0]  ram_f, ram_m;
   logic [DATA_W-1:0]  rf_value, rm_value;
   logic [MEM_AW-1:0]  mem_addr;
   logic               reg_wr;
   exec_result_type    exe_result;

   assign exe_fire   = s1_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !s1_valid_ff || exe_fire;
   assign req_fire   = req_tvalid && req_tready;

   assign s1_slot_f = reg_slot(s1_first_ff);
   assign s1_slot_m = reg_slot(s1_middle_ff);
   assign rd_slot_f = req_fire ? reg_slot(req_tdata[3:0]) : s1_slot_f;
   assign rd_slot_m = req_fire ? reg_slot(req_tdata[7:4]) : s1_slot_m;

   assign reg_wr  = exe_fire && exe_result.reg_written;
   assign wr_slot = reg_slot(exe_result.shown_index);

   brm_ram #(.WIDTH(DATA_W), .DEPTH(REG_COUNT)) u_rf_port_f (
      .clock   (clock),
      .wr_en   (reg_wr),
      .wr_addr (wr_slot),
      .wr_data (exe_result.shown_value),
      .rd_addr (rd_slot_f),
      .rd_data (ram_f)
   );

   brm_ram #(.WIDTH(DATA_W), .DEPTH(REG_COUNT)) u_rf_port_m (
      .clock   (clock),
      .wr_en   (reg_wr),
      .wr_addr (wr_slot),
      .wr_data (exe_result.shown_value),
      .rd_addr (rd_slot_m),
      .rd_data (ram_m)
   );

   // bypass the write made at the same edge as the read
   always_comb begin
      priority if (byp_valid_ff && byp_slot_ff == s1_slot_f) begin
         rf_value = byp_data_ff;
      end else if (rf_valid_ff[s1_slot_f]) begin
         rf_value = ram_f;
      end else begin
         rf_value = reg_reset_value(s1_slot_f);
      end
      priority if (byp_valid_ff && byp_slot_ff == s1_slot_m) begin
         rm_value = byp_data_ff;
      end else if (rf_valid_ff[s1_slot_m]) begin
         rm_value = ram_m;
      end else begin
         rm_value = reg_reset_value(s1_slot_m);
      end
   end

   brm_exec u_exec (
      .func         (s1_func_ff),
      .middle_field (s1_middle_ff),
      .last_field   (s1_last_ff),
      .rf_value     (rf_value),
      .rm_value     (rm_value),
      .mem_rd_data  (dmem_ff[mem_addr]),
      .mem_addr     (mem_addr),
      .result       (exe_result)
   );

   assign s1_valid_in  = req_fire || (s1_valid_ff && !exe_fire);
   assign rsp_valid_in = exe_fire || (rsp_valid_ff && !rsp_tready);
   assign byp_valid_in = reg_wr;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         byp_valid_ff <= 1'b0;
         rf_valid_ff  <= '0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         byp_valid_ff <= byp_valid_in;
         if (reg_wr) begin
            rf_valid_ff[wr_slot] <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < MEM_DEPTH; i++) begin
            dmem_ff[i] <= '0;
         end
      end else if (exe_fire && exe_result.mem_written) begin
         dmem_ff[mem_addr] <= rm_value;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         s1_func_ff   <= req_tuser;
         s1_first_ff  <= req_tdata[3:0];
         s1_middle_ff <= req_tdata[7:4];
         s1_last_ff   <= req_tdata[11:8];
      end
      if (exe_fire) begin
         rsp_ff <= exe_result;
      end
      if (reg_wr) begin
         byp_slot_ff <= wr_slot;
         byp_data_ff <= exe_result.shown_value;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {4'b0, rsp_ff.shown_value, rsp_ff.shown_index};
   assign rsp_tuser  = {rsp_ff.zero_flag, rsp_ff.mem_written, rsp_ff.reg_written};

endmodule

// File: tb/tb_byte_register_machine_execute_unit.sv
// Self-checking testbench for byte_register_machine_execute_unit: instructions
// are streamed in and each result word is checked against an in-bench execute model.
// Depends on brm_pkg and the RTL of the execute unit.
module tb_byte_register_machine_execute_unit import brm_pkg::*;;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int RANDOM_ITEMS = 450;
   localparam int MAX_GAP      = 12;
   localparam int LONG_HOLD    = 80;
   localparam int DRAIN_CYCLES = 10;
   localparam int CYCLE_LIMIT  = 200000;
   localparam int MAX_REPORTS  = 10;

   typedef struct {
      logic [FIELD_W-1:0] func;
      logic [FIELD_W-1:0] first;
      logic [FIELD_W-1:0] middle;
      logic [FIELD_W-1:0] last;
      bit                 drain_first;
      bit                 hold_rsp;
   } instr_word_type;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [REQ_TDATA_W-1:0] req_tdata = '0;
   logic [FIELD_W-1:0]     req_tuser = '0;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [RSP_TDATA_W-1:0] rsp_tdata;
   logic [RSP_TUSER_W-1:0] rsp_tuser;

   instr_word_type  instr_queue[$];
   exec_result_type results_due[$];

   logic [DATA_W-1:0] reg_model[REG_COUNT];
   logic [DATA_W-1:0] mem_model[MEM_DEPTH];

   int  req_offered = 0;
   int  req_taken = 0;
   int  rsp_taken = 0;
   int  hold_requests = 0;
   int  cycle_count = 0;
   int  errors = 0;
   int  store_count = 0;
   int  load_count = 0;
   int  equal_count = 0;
   bit  ops_seen[16];

   byte_register_machine_execute_unit dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic void add_instr(logic [FIELD_W-1:0] op, logic [FIELD_W-1:0] fa,
                                     logic [FIELD_W-1:0] fm, logic [FIELD_W-1:0] fl,
                                     bit drain = 1'b0, bit hold = 1'b0);
      instr_word_type item;
      item.func = op;
      item.first = fa;
      item.middle = fm;
      item.last = fl;
      item.drain_first = drain;
      item.hold_rsp = hold;
      instr_queue.push_back(item);
   endfunction

   function automatic void note_error(string msg);
      errors++;
      if (errors <= MAX_REPORTS) begin
         $display("[%0d] %s", cycle_count, msg);
      end
   endfunction

   // executes one instruction on the model state; sources read before the write
   function automatic exec_result_type execute_instr(logic [FIELD_W-1:0] op,
                                                     logic [FIELD_W-1:0] fa,
                                                     logic [FIELD_W-1:0] fm,
                                                     logic [FIELD_W-1:0] fl);
      exec_result_type   res;
      logic [DATA_W-1:0] ra;
      logic [DATA_W-1:0] rm;
      logic [DATA_W-1:0] val;
      int                addr;
      res = '0;
      val = '0;
      ra = reg_model[fa % REG_COUNT];
      rm = reg_model[fm % REG_COUNT];
      addr = (int'(ra) + int'(fl)) % MEM_DEPTH;
      ops_seen[op] = 1'b1;
      case (op)
         OP_SUB:  begin res.shown_index = fl; val = rm - ra;    res.reg_written = 1'b1; end
         OP_AND:  begin res.shown_index = fl; val = rm & ra;    res.reg_written = 1'b1; end
         OP_NOR:  begin res.shown_index = fl; val = ~(rm | ra); res.reg_written = 1'b1; end
         OP_OR:   begin res.shown_index = fl; val = rm | ra;    res.reg_written = 1'b1; end
         OP_ADD:  begin res.shown_index = fl; val = rm + ra;    res.reg_written = 1'b1; end
         OP_SLL: begin
            res.shown_index = fm;
            val = (fl >= 4'd8) ? '0 : ra << fl;
            res.reg_written = 1'b1;
         end
         OP_SRL: begin
            res.shown_index = fm;
            val = (fl >= 4'd8) ? '0 : ra >> fl;
            res.reg_written = 1'b1;
         end
         OP_ORI:  begin res.shown_index = fm; val = ra | fl; res.reg_written = 1'b1; end
         OP_ADDI: begin res.shown_index = fm; val = ra + fl; res.reg_written = 1'b1; end
         OP_ANDI: begin res.shown_index = fm; val = ra & fl; res.reg_written = 1'b1; end
         OP_SUBI: begin res.shown_index = fm; val = ra - fl; res.reg_written = 1'b1; end
         OP_LW: begin
            res.shown_index = fm;
            val = mem_model[addr];
            res.reg_written = 1'b1;
            load_count++;
         end
         OP_SW: begin
            res.shown_index = fm;
            val = rm;
            res.mem_written = 1'b1;
            mem_model[addr] = rm;
            store_count++;
         end
         OP_BEQ: begin
            res.zero_flag = (ra == rm);
            if (ra == rm) begin
               equal_count++;
            end
         end
         default: begin
         end
      endcase
      res.shown_value = val;
      if (res.reg_written) begin
         reg_model[res.shown_index % REG_COUNT] = val;
      end
      return res;
   endfunction

   // driver: one word per handshake, random gaps between words
   always @(negedge clock) begin : driver
      instr_word_type item;
      static int req_gap = 0;
      static bit send_burst = 1'b0;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!(req_tvalid && req_taken != req_offered)) begin
         if (req_gap > 0) begin
            req_gap--;
            req_tvalid <= 1'b0;
         end else if (instr_queue.size() == 0 ||
                      (instr_queue[0].drain_first && results_due.size() != 0)) begin
            req_tvalid <= 1'b0;
         end else begin
            item = instr_queue.pop_front();
            req_tuser  <= item.func;
            req_tdata  <= {4'b0, item.last, item.middle, item.first};
            req_tvalid <= 1'b1;
            req_offered++;
            if (item.hold_rsp) begin
               hold_requests++;
            end
            if ($urandom_range(0, 15) == 0) begin
               send_burst = !send_burst;
            end
            req_gap = send_burst ? 0 : $urandom_range(0, MAX_GAP);
         end
      end
   end

   // receiver: random stall after each word, plus one long hold-off on request
   always @(negedge clock) begin : receiver
      static int rsp_seen = 0;
      static int holds_begun = 0;
      static int hold_left = 0;
      static int rsp_wait = 0;
      static bit recv_burst = 1'b0;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (hold_requests != holds_begun) begin
            holds_begun = hold_requests;
            hold_left = LONG_HOLD;
         end
         if (rsp_taken != rsp_seen) begin
            rsp_seen = rsp_taken;
            if ($urandom_range(0, 15) == 0) begin
               recv_burst = !recv_burst;
            end
            rsp_wait = recv_burst ? 0 : $urandom_range(0, MAX_GAP);
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else if (rsp_wait > 0) begin
            rsp_wait--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   // monitor: check result words first, then predict for accepted instructions
   always @(posedge clock) begin : monitor
      exec_result_type got;
      exec_result_type want;
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d results outstanding",
                  cycle_count, results_due.size());
         $display("DONE: errors detected");
         $finish;
      end else if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            got.shown_index = rsp_tdata[3:0];
            got.shown_value = rsp_tdata[11:4];
            got.reg_written = rsp_tuser[0];
            got.mem_written = rsp_tuser[1];
            got.zero_flag   = rsp_tuser[2];
            rsp_taken++;
            if (results_due.size() == 0) begin
               note_error($sformatf("unexpected result idx=%0d val=%02h flags=%b",
                                    got.shown_index, got.shown_value, rsp_tuser));
            end else begin
               want = results_due.pop_front();
               if (got.shown_index !== want.shown_index ||
                   got.shown_value !== want.shown_value ||
                   got.reg_written !== want.reg_written ||
                   got.mem_written !== want.mem_written ||
                   got.zero_flag   !== want.zero_flag) begin
                  note_error($sformatf(
                     "result %0d: exp %0d/%02h/%b%b%b, got %0d/%02h/%b%b%b",
                     rsp_taken, want.shown_index, want.shown_value, want.reg_written,
                     want.mem_written, want.zero_flag, got.shown_index, got.shown_value,
                     got.reg_written, got.mem_written, got.zero_flag));
               end
            end
         end
         if (req_tvalid && req_tready) begin
            results_due.push_back(execute_instr(req_tuser, req_tdata[3:0],
                                                req_tdata[7:4], req_tdata[11:8]));
            req_taken++;
         end
      end
   end

   initial begin : sequencer
      int ops_covered;
      for (int i = 0; i < REG_COUNT; i++) begin
         reg_model[i] = (i == SP_INDEX % REG_COUNT) ? SP_RESET : '0;
      end
      for (int i = 0; i < MEM_DEPTH; i++) begin
         mem_model[i] = '0;
      end

      // directed: extremes, every opcode, shift limits, wrap, overlap, no-write ops
      add_instr(OP_ADDI, 4'd0,  4'd1,  4'd15);
      add_instr(OP_ADDI, 4'd6,  4'd2,  4'd15);
      add_instr(OP_SUBI, 4'd0,  4'd3,  4'd1);
      add_instr(OP_SLL,  4'd3,  4'd4,  4'd7);
      add_instr(OP_SLL,  4'd3,  4'd5,  4'd8);
      add_instr(OP_SRL,  4'd3,  4'd7,  4'd15);
      add_instr(OP_SRL,  4'd3,  4'd8,  4'd3);
      add_instr(OP_ADD,  4'd3,  4'd3,  4'd9);
      add_instr(OP_SUB,  4'd3,  4'd0,  4'd10);
      add_instr(OP_AND,  4'd3,  4'd4,  4'd11);
      add_instr(OP_OR,   4'd8,  4'd4,  4'd12);
      add_instr(OP_NOR,  4'd0,  4'd0,  4'd13);
      add_instr(OP_ANDI, 4'd3,  4'd14, 4'd10);
      add_instr(OP_ORI,  4'd0,  4'd15, 4'd15);
      add_instr(OP_SW,   4'd3,  4'd1,  4'd15);
      add_instr(OP_LW,   4'd3,  4'd0,  4'd15);
      add_instr(OP_LW,   4'd0,  4'd11, 4'd0);
      add_instr(OP_BEQ,  4'd1,  4'd1,  4'd0);
      add_instr(OP_BEQ,  4'd1,  4'd2,  4'd15);
      add_instr(OP_BNE,  4'd1,  4'd2,  4'd3);
      add_instr(OP_JUMP, 4'd15, 4'd15, 4'd15);
      add_instr(OP_ADDI, 4'd2,  4'd2,  4'd1);
      add_instr(OP_ADD,  4'd9,  4'd9,  4'd9);
      add_instr(OP_SW,   4'd15, 4'd15, 4'd0);

      // random: two pauses for a full drain, one long receiver hold-off
      for (int i = 0; i < RANDOM_ITEMS; i++) begin
         add_instr(4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)),
                   4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)),
                   (i == 0 || i == 250), (i == 100));
      end

      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      while (instr_queue.size() != 0 || req_taken != req_offered || results_due.size() != 0) begin
         @(negedge clock);
      end
      repeat (DRAIN_CYCLES) @(posedge clock);

      while (results_due.size() != 0) begin
         want_missing : begin
            exec_result_type left;
            left = results_due.pop_front();
            note_error($sformatf("missing result idx=%0d val=%02h",
                                 left.shown_index, left.shown_value));
         end
      end

      ops_covered = 0;
      for (int i = 0; i < 16; i++) begin
         ops_covered += ops_seen[i];
      end
      $display("ran %0d instructions covering %0d of 16 opcodes, checked %0d results",
               req_taken, ops_covered, rsp_taken);
      $display("%0d stores, %0d loads, %0d equal branches, %0d mismatches",
               store_count, load_count, equal_count, errors);
      if (errors == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule
